/* hw/rtl/saa_pkg.sv */
package saa_pkg;

	localparam int MAX_ROWS     = 64;
	localparam int MAX_SIZE     = 4096;
	localparam int INITIAL_SIZE = 128;

	localparam int DIM_W   = 12;
	localparam int COORD_W = 12;
	localparam int SIZE_W  = 13;
	localparam int FFL_W   = 8;
	localparam int ROW_AW  = $clog2(MAX_ROWS);
	localparam int CNT_W   = $clog2(MAX_ROWS + 1);

	localparam logic [FFL_W-1:0]  FFL_RESET = FFL_W'(3);
	localparam logic [SIZE_W-1:0] SIZE_INIT = SIZE_W'(INITIAL_SIZE);
	localparam logic [SIZE_W-1:0] SIZE_HALF = SIZE_W'(MAX_SIZE / 2);

	// floor(h / 10) == (h * 3277) >> 15 for every 12-bit h.
	localparam int                RECIP_W  = 12;
	localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'(3277);
	localparam int                RECIP_SH = 15;

	typedef enum logic [1:0] {
		STAT_PLACED  = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_TOO_BIG = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RK_HIT,
		RK_NEW,
		RK_FULL,
		RK_BIG
	} res_kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_DECIDE,
		S_GROW
	} ctl_state_t;

	typedef struct packed {
		logic [COORD_W-1:0] top;
		logic [DIM_W-1:0]   span;
		logic [SIZE_W-1:0]  used;
	} row_t;

	typedef struct packed {
		logic      accept;
		logic      prep;
		logic      scan;
		logic      grow;
		logic      commit_hit;
		logic      commit_new;
		logic      res_load;
		res_kind_t res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic found;
		logic row_full;
		logic rows_empty;
		logic scan_last;
		logic grow_need;
		logic grow_over;
		logic out_busy;
	} dp_status_t;

endpackage

/* hw/rtl/saa_ifs.sv */
interface saa_req_if;
	import saa_pkg::*;

	logic             valid;
	logic             ready;
	logic [DIM_W-1:0] req_width;
	logic [DIM_W-1:0] req_height;

	modport source (output valid, req_width, req_height, input ready);
	modport sink   (input valid, req_width, req_height, output ready);
endinterface

interface saa_res_if;
	import saa_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] rect_x;
	logic [COORD_W-1:0] rect_y;
	logic [SIZE_W-1:0]  atlas_size;
	logic               grew;
	logic [1:0]         status;

	modport source (output valid, rect_x, rect_y, atlas_size, grew, status, input ready);
	modport sink   (input valid, rect_x, rect_y, atlas_size, grew, status, output ready);
endinterface

interface saa_cfg_if;
	import saa_pkg::*;

	logic             valid;
	logic             ready;
	logic [FFL_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/saa_ram.sv */
module saa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hw/rtl/saa_ctrl.sv */
module saa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  saa_pkg::dp_status_t sts,
	output saa_pkg::dp_cmd_t    cmd
);
	import saa_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_PREP;
			end
			S_PREP: begin
				state_d = sts.rows_empty ? S_DECIDE : S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_last) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.found || sts.row_full) begin
					if (!sts.out_busy) state_d = S_IDLE;
				end else begin
					state_d = S_GROW;
				end
			end
			S_GROW: begin
				if (!(sts.grow_need && !sts.grow_over) && !sts.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			S_PREP: cmd.prep = 1'b1;
			S_SCAN: cmd.scan = 1'b1;
			S_DECIDE: begin
				if (!sts.out_busy) begin
					if (sts.found) begin
						cmd.commit_hit = 1'b1;
						cmd.res_load   = 1'b1;
						cmd.res_sel    = RK_HIT;
					end else if (sts.row_full) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RK_FULL;
					end
				end
			end
			S_GROW: begin
				if (sts.grow_need) begin
					if (!sts.grow_over) begin
						cmd.grow = 1'b1;
					end else if (!sts.out_busy) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RK_BIG;
					end
				end else if (!sts.out_busy) begin
					cmd.commit_new = 1'b1;
					cmd.res_load   = 1'b1;
					cmd.res_sel    = RK_NEW;
				end
			end
			default: ;
		endcase
	end
endmodule

/* hw/rtl/saa_dp.sv */
module saa_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  saa_pkg::dp_cmd_t             cmd,
	output saa_pkg::dp_status_t          sts,
	input  logic [saa_pkg::DIM_W-1:0]    req_width,
	input  logic [saa_pkg::DIM_W-1:0]    req_height,
	input  logic                         cfg_we,
	input  logic [saa_pkg::FFL_W-1:0]    cfg_data,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [saa_pkg::COORD_W-1:0]  rect_x,
	output logic [saa_pkg::COORD_W-1:0]  rect_y,
	output logic [saa_pkg::SIZE_W-1:0]   atlas_size,
	output logic                         grew,
	output logic [1:0]                   status
);
	import saa_pkg::*;

	// Persistent allocator state.
	logic [CNT_W-1:0]  row_cnt_q;
	logic [SIZE_W-1:0] next_line_q;
	logic [SIZE_W-1:0] side_q;

	// Per-request working registers.
	logic [DIM_W-1:0]   w_q, h_q;
	logic [SIZE_W-1:0]  rh_q;
	logic [CNT_W-1:0]   idx_q;
	logic               found_q;
	logic [ROW_AW-1:0]  best_idx_q;
	logic [DIM_W-1:0]   best_span_q;
	logic [COORD_W-1:0] best_top_q;
	logic [SIZE_W-1:0]  best_used_q;
	logic [SIZE_W-1:0]  s_q;
	logic               g_q;

	// Result register.
	logic               out_vld_q;
	logic [COORD_W-1:0] res_x_q, res_y_q;
	logic [SIZE_W-1:0]  res_size_q;
	logic               res_grew_q;
	status_t            res_stat_q;

	// Row table.
	row_t              rd_row, wr_row;
	logic              ram_we;
	logic [ROW_AW-1:0] ram_waddr;

	assign ram_we    = cmd.commit_hit || cmd.commit_new;
	assign ram_waddr = cmd.commit_new ? row_cnt_q[ROW_AW-1:0] : best_idx_q;

	always_comb begin
		if (cmd.commit_new) begin
			wr_row.top  = next_line_q[COORD_W-1:0];
			wr_row.span = rh_q[DIM_W-1:0];
			wr_row.used = {1'b0, w_q};
		end else begin
			wr_row.top  = best_top_q;
			wr_row.span = best_span_q;
			wr_row.used = SIZE_W'({1'b0, best_used_q} + {2'b00, w_q});
		end
	end

	saa_ram #(
		.WIDTH ($bits(row_t)),
		.DEPTH (MAX_ROWS)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_row),
		.raddr (idx_q[ROW_AW-1:0]),
		.rdata (rd_row)
	);

	// New row span: h + h / 10 through a reciprocal multiply.
	logic [DIM_W+RECIP_W-1:0] h_prod;
	logic [SIZE_W-1:0]        rh_calc;

	assign h_prod  = h_q * RECIP_10;
	assign rh_calc = {1'b0, h_q} + SIZE_W'(h_prod[DIM_W+RECIP_W-1:RECIP_SH]);

	// Row test on the entry read in the previous cycle (entry idx_q - 1).
	logic [DIM_W+3:0]  h_x10;
	logic [DIM_W+2:0]  span_x7;
	logic [SIZE_W:0]   used_sum;
	logic              row_ok, row_better;
	logic [CNT_W-1:0]  idx_m1;

	assign h_x10      = {1'b0, h_q, 3'b000} + {3'b000, h_q, 1'b0};
	assign span_x7    = {rd_row.span, 3'b000} - {3'b000, rd_row.span};
	assign used_sum   = {1'b0, rd_row.used} + {2'b00, w_q};
	assign row_ok     = (h_x10 >= {1'b0, span_x7}) && (h_q <= rd_row.span)
	                    && (used_sum <= {1'b0, side_q});
	assign row_better = !found_q || (rd_row.span <= best_span_q);
	assign idx_m1     = idx_q - CNT_W'(1);

	logic [SIZE_W:0] line_end;
	assign line_end = {1'b0, next_line_q} + {1'b0, rh_q};

	assign sts.found      = found_q;
	assign sts.row_full   = (row_cnt_q == CNT_W'(MAX_ROWS));
	assign sts.rows_empty = (row_cnt_q == '0);
	assign sts.scan_last  = (idx_q == row_cnt_q);
	assign sts.grow_need  = (line_end >= {1'b0, s_q}) || ({1'b0, w_q} >= s_q);
	assign sts.grow_over  = (s_q > SIZE_HALF);
	assign sts.out_busy   = out_vld_q && !res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q   <= '0;
			next_line_q <= SIZE_W'(FFL_RESET);
			side_q      <= SIZE_INIT;
			idx_q       <= '0;
			found_q     <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we && row_cnt_q == '0) begin
				next_line_q <= SIZE_W'(cfg_data);
			end
			if (cmd.accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.prep || cmd.scan) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.scan && row_ok) begin
				found_q <= 1'b1;
			end
			if (cmd.commit_new) begin
				row_cnt_q   <= row_cnt_q + CNT_W'(1);
				next_line_q <= line_end[SIZE_W-1:0];
				side_q      <= s_q;
			end
			if (cmd.res_load) begin
				out_vld_q <= 1'b1;
			end else if (res_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			w_q <= req_width;
			h_q <= req_height;
		end
		if (cmd.prep) begin
			rh_q <= rh_calc;
			s_q  <= side_q;
			g_q  <= 1'b0;
		end
		if (cmd.scan && row_ok && row_better) begin
			best_idx_q  <= idx_m1[ROW_AW-1:0];
			best_span_q <= rd_row.span;
			best_top_q  <= rd_row.top;
			best_used_q <= rd_row.used;
		end
		if (cmd.grow) begin
			s_q <= {s_q[SIZE_W-2:0], 1'b0};
			g_q <= 1'b1;
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RK_HIT: begin
					res_x_q    <= best_used_q[COORD_W-1:0];
					res_y_q    <= best_top_q;
					res_size_q <= side_q;
					res_grew_q <= 1'b0;
					res_stat_q <= STAT_PLACED;
				end
				RK_NEW: begin
					res_x_q    <= '0;
					res_y_q    <= next_line_q[COORD_W-1:0];
					res_size_q <= s_q;
					res_grew_q <= g_q;
					res_stat_q <= STAT_PLACED;
				end
				RK_FULL: begin
					res_x_q    <= '0;
					res_y_q    <= '0;
					res_size_q <= side_q;
					res_grew_q <= 1'b0;
					res_stat_q <= STAT_FULL;
				end
				default: begin
					res_x_q    <= '0;
					res_y_q    <= '0;
					res_size_q <= side_q;
					res_grew_q <= 1'b0;
					res_stat_q <= STAT_TOO_BIG;
				end
			endcase
		end
	end

	assign res_valid  = out_vld_q;
	assign rect_x     = res_x_q;
	assign rect_y     = res_y_q;
	assign atlas_size = res_size_q;
	assign grew       = res_grew_q;
	assign status     = res_stat_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q <= CNT_W'(MAX_ROWS))
		else $error("row count beyond table depth");

	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_new |-> !sts.row_full && !found_q)
		else $error("new row opened with full table or a matching row");

	a_hit_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_hit |-> found_q)
		else $error("row update without a matching row");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !(out_vld_q && !res_ready))
		else $error("pending result overwritten");

	a_side_growth: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_new |=> next_line_q < side_q)
		else $error("row extends past the atlas side");
`endif
endmodule

/* hw/rtl/shelf_atlas_allocator.sv */
// Channel  Dir  Payload                                      Handshake
// cfg      in   data (first free line, 8 bits)               valid/ready, ready always high
// req      in   req_width, req_height (12 bits each)         valid/ready
// res      out  rect_x, rect_y, atlas_size, grew, status     valid/ready
//
// A request goes through prep, a scan of the N stored rows (none if the table is empty) and
// decide, which loads a hit or full-table result; others go to grow for side doublings.
// The row table is a RAM with one read port, read one row per cycle, which sets the scan.
// A finished result waits in an output register; the next request is taken meanwhile and
// stalls only if its own result is ready before the previous one has been taken.
// Reset empties the row table at once, with no clearing pass.
module shelf_atlas_allocator (
	input  logic      clk,
	input  logic      arst_n,
	saa_cfg_if.sink   cfg,
	saa_req_if.sink   req,
	saa_res_if.source res
);
	import saa_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t sts;

	assign cfg.ready = 1'b1;

	saa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	saa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_width  (req.req_width),
		.req_height (req.req_height),
		.cfg_we     (cfg.valid && cfg.ready),
		.cfg_data   (cfg.data),
		.res_valid  (res.valid),
		.res_ready  (res.ready),
		.rect_x     (res.rect_x),
		.rect_y     (res.rect_y),
		.atlas_size (res.atlas_size),
		.grew       (res.grew),
		.status     (res.status)
	);
endmodule
